>>> design/dhw_pkg.sv
// types and constants shared by the heartbeat watchdog modules
`timescale 1ns / 1ps
package dhw_pkg;

  localparam int unsigned DEV_W  = 3;
  localparam int unsigned CFG_W  = 41;
  localparam int unsigned MASK_W = 7;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned NREG   = 7;

  // settings register fields
  localparam int unsigned EN_BIT  = 40;
  localparam int unsigned PRI_LSB = 32;
  localparam int unsigned ON_LSB  = 16;
  localparam int unsigned OFF_LSB = 0;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned TICKS_W = 16;

  localparam logic [DEV_W-1:0] NONE_DEV = 3'd7;

  localparam logic [MODE_W-1:0] MODE_TICK = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SCAN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BEAT = 2'd2;

  localparam logic [CFG_W-1:0] SETTINGS_RESET [NREG] = '{
    41'd1163938758686, 41'd1146756923402, 41'd1142461956106, 41'd1142461956106,
    41'd1142461956106, 41'd1146756923397, 41'd1163942691316
  };

  typedef struct packed {
    logic             start;
    logic             do_tick;
    logic             do_beat;
    logic             do_scan;
    logic             scan_last;
    logic [DEV_W-1:0] idx;
  } dhw_cmd_t;

endpackage

>>> design/dhw_ctrl.sv
// controller: sequences ticks, heartbeats, device scans and result handoff
`timescale 1ns / 1ps
module dhw_ctrl #(
  parameter int unsigned DEVICES = 7
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic [dhw_pkg::MODE_W-1:0] mode_i,
  input  logic                      out_stall_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  output dhw_pkg::dhw_cmd_t         cmd_o
);
  import dhw_pkg::*;

  localparam int unsigned IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEVICES - 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_RESP = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             accept;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = (state_q == ST_RESP);
  assign accept      = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    cmd_o         = '0;
    cmd_o.idx     = DEV_W'(idx_q);
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.start   = 1'b1;
          cmd_o.do_tick = (mode_i == MODE_TICK);
          cmd_o.do_beat = (mode_i == MODE_BEAT);
          idx_d         = '0;
          state_d       = (mode_i == MODE_SCAN) ? ST_SCAN : ST_RESP;
        end
      end
      ST_SCAN: begin
        cmd_o.do_scan   = 1'b1;
        cmd_o.scan_last = (idx_q == LAST_IDX);
        if (idx_q == LAST_IDX) begin
          state_d = ST_RESP;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      ST_RESP: begin
        if (!out_stall_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

endmodule

>>> design/dhw_datapath.sv
// datapath: settings, time counter, per-device beat times, flags and results
`timescale 1ns / 1ps
module dhw_datapath #(
  parameter int unsigned DEVICES   = 7,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dhw_pkg::dhw_cmd_t          cmd_i,
  input  logic [dhw_pkg::DEV_W-1:0]  device_i,
  input  logic                       data_bad_i,
  input  logic                       cfg_we_i,
  input  logic [dhw_pkg::DEV_W-1:0]  cfg_index_i,
  input  logic [dhw_pkg::CFG_W-1:0]  cfg_data_i,
  output logic [dhw_pkg::MASK_W-1:0] lost_mask_o,
  output logic [dhw_pkg::MASK_W-1:0] error_mask_o,
  output logic                       any_lost_o,
  output logic [dhw_pkg::DEV_W-1:0]  top_device_o,
  output logic [dhw_pkg::MASK_W-1:0] lost_recovery_mask_o,
  output logic                       data_recovery_o,
  output logic [TIME_BITS-1:0]       heartbeat_interval_o
);
  import dhw_pkg::*;

  localparam int unsigned IDX_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;

  logic [CFG_W-1:0]     settings_q [DEVICES];
  logic [TIME_BITS-1:0] tick_q;
  logic [TIME_BITS-1:0] newest_q [DEVICES];
  logic [TIME_BITS-1:0] online_q [DEVICES];
  logic [DEVICES-1:0]   lost_q, error_q, bad_q;
  logic [DEV_W-1:0]     last_top_q;

  // per-item results
  logic                 any_q;
  logic [DEVICES-1:0]   recov_q;
  logic                 drec_q;
  logic [TIME_BITS-1:0] interval_q;
  logic [DEV_W-1:0]     best_q;
  logic [PRI_W-1:0]     best_pri_q;

  logic [IDX_W-1:0]     rd_idx;
  logic [CFG_W-1:0]     cur_set;
  logic [PRI_W-1:0]     cur_pri;
  logic [TIME_BITS-1:0] age, settle_age;
  logic                 enabled, timed_out, settling, better, beat_ok;

  // one read address: heartbeat device or scan position
  assign rd_idx     = cmd_i.do_beat ? device_i[IDX_W-1:0] : cmd_i.idx[IDX_W-1:0];
  assign cur_set    = settings_q[rd_idx];
  assign cur_pri    = cur_set[PRI_LSB +: PRI_W];
  assign enabled    = cur_set[EN_BIT];
  assign age        = tick_q - newest_q[rd_idx];
  assign settle_age = tick_q - online_q[rd_idx];
  assign timed_out  = age > TIME_BITS'(cur_set[OFF_LSB +: TICKS_W]);
  assign settling   = settle_age < TIME_BITS'(cur_set[ON_LSB +: TICKS_W]);
  assign better     = timed_out && (cur_pri > best_pri_q);
  assign beat_ok    = cmd_i.do_beat && (device_i < DEV_W'(DEVICES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEVICES; i++) begin
        settings_q[i] <= SETTINGS_RESET[i];
      end
    end else if (cfg_we_i && (cfg_index_i < DEV_W'(DEVICES))) begin
      settings_q[cfg_index_i[IDX_W-1:0]] <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q     <= '0;
      lost_q     <= '1;
      error_q    <= '1;
      bad_q      <= '1;
      last_top_q <= NONE_DEV;
      for (int i = 0; i < DEVICES; i++) begin
        newest_q[i] <= '0;
        online_q[i] <= '0;
      end
    end else begin
      if (cmd_i.do_tick) begin
        tick_q <= tick_q + 1'b1;
      end
      if (beat_ok) begin
        newest_q[rd_idx] <= tick_q;
        if (lost_q[rd_idx]) begin
          lost_q[rd_idx]   <= 1'b0;
          online_q[rd_idx] <= tick_q;
        end
        bad_q[rd_idx] <= data_bad_i;
        if (data_bad_i) begin
          error_q[rd_idx] <= 1'b1;
        end
      end
      if (cmd_i.do_scan && enabled) begin
        if (timed_out) begin
          if (!error_q[rd_idx]) begin
            lost_q[rd_idx]  <= 1'b1;
            error_q[rd_idx] <= 1'b1;
          end
        end else if (settling) begin
          lost_q[rd_idx]  <= 1'b0;
          error_q[rd_idx] <= 1'b1;
        end else begin
          lost_q[rd_idx]  <= 1'b0;
          error_q[rd_idx] <= bad_q[rd_idx];
        end
      end
      if (cmd_i.scan_last) begin
        last_top_q <= (enabled && better) ? cmd_i.idx : best_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      any_q      <= 1'b0;
      recov_q    <= '0;
      drec_q     <= 1'b0;
      interval_q <= '0;
      best_q     <= NONE_DEV;
      best_pri_q <= '0;
    end else if (cmd_i.start) begin
      any_q      <= 1'b0;
      recov_q    <= '0;
      best_q     <= NONE_DEV;
      best_pri_q <= '0;
      drec_q     <= beat_ok && data_bad_i;
      interval_q <= beat_ok ? age : '0;
    end else if (cmd_i.do_scan && enabled && timed_out) begin
      any_q           <= 1'b1;
      recov_q[rd_idx] <= 1'b1;
      if (better) begin
        best_q     <= cmd_i.idx;
        best_pri_q <= cur_pri;
      end
    end
  end

  assign lost_mask_o          = MASK_W'(lost_q);
  assign error_mask_o         = MASK_W'(error_q);
  assign any_lost_o           = any_q;
  assign top_device_o         = last_top_q;
  assign lost_recovery_mask_o = MASK_W'(recov_q);
  assign data_recovery_o      = drec_q;
  assign heartbeat_interval_o = interval_q;

endmodule

>>> design/device_heartbeat_watchdog_core.sv
// heartbeat watchdog: up to seven devices, tick/scan/heartbeat items
// Usage:
//   The input channel (in_valid_i / in_stall_o) carries one item per transaction:
//   mode (tick, scan or heartbeat), device index and data-bad flag. Every item
//   gives exactly one result transaction on the output channel
//   (out_valid_o / out_stall_i) with lost and error masks, the scan summary,
//   the data recovery request and the heartbeat interval.
//   Tick and heartbeat items are done in the cycle they are taken; the result
//   is valid on the next cycle. A scan walks the devices one per cycle through
//   the shared compare logic. One item is in flight at a time: a new item is
//   taken in the cycle after the result is delivered. While the receiver
//   stalls, the result holds and in_stall_o stays high.
//   Settings registers are written through cfg_we_i / cfg_index_i / cfg_data_i;
//   the user must write them only while the block is idle, as the block itself
//   does not enforce it. Reset loads the default settings, clears the time
//   counter and beat times, marks every device lost and in error, and sets the
//   top device to none.
`timescale 1ns / 1ps
module device_heartbeat_watchdog_core #(
  parameter int unsigned DEVICES   = 7,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [dhw_pkg::MODE_W-1:0] mode_i,
  input  logic [dhw_pkg::DEV_W-1:0]  device_i,
  input  logic                       data_bad_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [dhw_pkg::MASK_W-1:0] lost_mask_o,
  output logic [dhw_pkg::MASK_W-1:0] error_mask_o,
  output logic                       any_lost_o,
  output logic [dhw_pkg::DEV_W-1:0]  top_device_o,
  output logic [dhw_pkg::MASK_W-1:0] lost_recovery_mask_o,
  output logic                       data_recovery_o,
  output logic [TIME_BITS-1:0]       heartbeat_interval_o,
  input  logic                       cfg_we_i,
  input  logic [dhw_pkg::DEV_W-1:0]  cfg_index_i,
  input  logic [dhw_pkg::CFG_W-1:0]  cfg_data_i
);
  import dhw_pkg::*;

  dhw_cmd_t cmd;

  dhw_ctrl #(
    .DEVICES (DEVICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .mode_i      (mode_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  dhw_datapath #(
    .DEVICES   (DEVICES),
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .device_i             (device_i),
    .data_bad_i           (data_bad_i),
    .cfg_we_i             (cfg_we_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .lost_mask_o          (lost_mask_o),
    .error_mask_o         (error_mask_o),
    .any_lost_o           (any_lost_o),
    .top_device_o         (top_device_o),
    .lost_recovery_mask_o (lost_recovery_mask_o),
    .data_recovery_o      (data_recovery_o),
    .heartbeat_interval_o (heartbeat_interval_o)
  );

endmodule
